FILE: src/mavu_pkg.sv
// ----------------------------------------------------------------------------
// mavu_pkg
// Shared constants, types and codes of the multi-turn angle and velocity unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mavu_pkg;

  localparam int RAW_W    = 14;
  localparam int TIMER_W  = 16;
  localparam int TURN_W   = 18;
  localparam int ANGLE_W  = 32;
  localparam int DELTA_W  = ANGLE_W + 1;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // counts per revolution
  localparam int COUNTS_PER_REV = 16384;

  localparam int US_W           = 20;
  localparam logic [US_W-1:0]    US_PER_S   = US_W'(1000000);
  localparam logic [TIMER_W-1:0] DEFAULT_DT = TIMER_W'(1000);
  localparam logic [RAW_W-1:0]   THRESH_RST = RAW_W'(13108);

  // split of |delta| for the two partial products
  localparam int LO_W     = 16;
  localparam int HI_W     = DELTA_W - LO_W;
  localparam int PP_LO_W  = LO_W + US_W;
  localparam int PP_HI_W  = HI_W + US_W;
  localparam int PROD_RAW = DELTA_W + US_W;

  // divider retires two quotient bits per cycle
  localparam int DIV_STEPS = (PROD_RAW + 1) / 2;
  localparam int PROD_W    = 2 * DIV_STEPS;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // register word indexes
  localparam logic [0:0] REG_WRAP_THRESHOLD = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FULL,
    ST_DELTA,
    ST_ABS,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_DIV,
    ST_SAT
  } mavu_state_e;

  typedef struct packed {
    logic load;
    logic calc_full;
    logic calc_delta;
    logic calc_abs;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic out_load;
  } mavu_cmd_t;

  typedef struct packed {
    logic div_last;
  } mavu_status_t;

endpackage

`default_nettype wire

FILE: src/multiturn_angle_and_velocity_unit.sv
// ----------------------------------------------------------------------------
// multiturn_angle_and_velocity_unit
// Unwraps a 14-bit absolute angle into a multi-turn count and estimates
// velocity in counts per second from a down-counting microsecond timer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid_i/in_stall_o  | raw_angle_i, timer_count_i
//  out     | source    | out_valid_o/out_stall_i| full_angle_o, velocity_o
//  cfg     | APB slave | psel/penable/pready    | wrap_threshold at 0x0
//
//  An item runs the full, delta, abs, two multiply and divider steps
//  before the next accept; the divider is the two-bit-per-cycle restoring
//  divider over the 54-bit product. The result is loaded into the output
//  register in the step after the divider ends; a stall there holds the
//  sequencer in its last step, while a taken result lets a new beat in
//  right away. Reset clears the unwrap state and loads the threshold default.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multiturn_angle_and_velocity_unit #(
  parameter int COUNTS_PER_REV = mavu_pkg::COUNTS_PER_REV
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [mavu_pkg::RAW_W-1:0]     raw_angle_i,
  input  wire logic [mavu_pkg::TIMER_W-1:0]   timer_count_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [mavu_pkg::ANGLE_W-1:0] full_angle_o,
  output logic signed [mavu_pkg::ANGLE_W-1:0] velocity_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mavu_pkg::APB_AW-1:0]    paddr,
  input  wire logic [mavu_pkg::APB_DW-1:0]    pwdata,
  output logic [mavu_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  mavu_pkg::mavu_cmd_t    cmd;
  mavu_pkg::mavu_status_t status;
  logic                   thresh_we;
  logic                   sel_thresh;
  logic [mavu_pkg::RAW_W-1:0] wrap_threshold;

  assign pready     = 1'b1;
  assign sel_thresh = (paddr[2] == mavu_pkg::REG_WRAP_THRESHOLD);
  assign thresh_we  = psel && penable && pwrite && pready && sel_thresh;
  assign prdata     = sel_thresh ? mavu_pkg::APB_DW'(wrap_threshold) : '0;

  mavu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mavu_dp #(
    .COUNTS_PER_REV (COUNTS_PER_REV)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .raw_angle_i      (raw_angle_i),
    .timer_count_i    (timer_count_i),
    .thresh_we_i      (thresh_we),
    .thresh_wdata_i   (pwdata[mavu_pkg::RAW_W-1:0]),
    .wrap_threshold_o (wrap_threshold),
    .full_angle_o     (full_angle_o),
    .velocity_o       (velocity_o)
  );

endmodule

`default_nettype wire

FILE: src/mavu_ctrl.sv
// ----------------------------------------------------------------------------
// mavu_ctrl
// Sequencer: accepts a beat, walks the datapath steps, owns output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mavu_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  input  wire mavu_pkg::mavu_status_t status_i,
  output mavu_pkg::mavu_cmd_t        cmd_o
);

  mavu_pkg::mavu_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != mavu_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mavu_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      mavu_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = mavu_pkg::ST_FULL;
        end
      end
      mavu_pkg::ST_FULL: begin
        cmd_o.calc_full = 1'b1;
        state_d         = mavu_pkg::ST_DELTA;
      end
      mavu_pkg::ST_DELTA: begin
        cmd_o.calc_delta = 1'b1;
        state_d          = mavu_pkg::ST_ABS;
      end
      mavu_pkg::ST_ABS: begin
        cmd_o.calc_abs = 1'b1;
        state_d        = mavu_pkg::ST_MUL_LO;
      end
      mavu_pkg::ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = mavu_pkg::ST_MUL_HI;
      end
      mavu_pkg::ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = mavu_pkg::ST_DIV;
      end
      mavu_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = mavu_pkg::ST_SAT;
        end
      end
      mavu_pkg::ST_SAT: begin
        // wait here while the previous result still sits in the output reg
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = mavu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mavu_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output overwritten while stalled");

  a_load_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == mavu_pkg::ST_FULL) && in_stall_o)
    else $error("accepted beat did not start the sequence");

  a_div_follows_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mavu_pkg::ST_MUL_HI) |=> (state_q == mavu_pkg::ST_DIV))
    else $error("divider did not start after product");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command");

endmodule

`default_nettype wire

FILE: src/mavu_dp.sv
// ----------------------------------------------------------------------------
// mavu_dp
// Datapath: turn unwrap, elapsed time, full angle, product, divider, clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mavu_dp #(
  parameter int COUNTS_PER_REV = mavu_pkg::COUNTS_PER_REV
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire mavu_pkg::mavu_cmd_t            cmd_i,
  output mavu_pkg::mavu_status_t              status_o,
  input  wire logic [mavu_pkg::RAW_W-1:0]     raw_angle_i,
  input  wire logic [mavu_pkg::TIMER_W-1:0]   timer_count_i,
  input  wire logic                           thresh_we_i,
  input  wire logic [mavu_pkg::RAW_W-1:0]     thresh_wdata_i,
  output logic [mavu_pkg::RAW_W-1:0]          wrap_threshold_o,
  output logic signed [mavu_pkg::ANGLE_W-1:0] full_angle_o,
  output logic signed [mavu_pkg::ANGLE_W-1:0] velocity_o
);

  localparam int RAW_W   = mavu_pkg::RAW_W;
  localparam int TIMER_W = mavu_pkg::TIMER_W;
  localparam int TURN_W  = mavu_pkg::TURN_W;
  localparam int ANGLE_W = mavu_pkg::ANGLE_W;
  localparam int DELTA_W = mavu_pkg::DELTA_W;
  localparam int PROD_W  = mavu_pkg::PROD_W;
  localparam int LO_W    = mavu_pkg::LO_W;
  localparam int CNT_W   = mavu_pkg::CNT_W;
  localparam logic [ANGLE_W-1:0] CPR_WORD = ANGLE_W'(COUNTS_PER_REV);
  localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(mavu_pkg::DIV_STEPS - 1);
  localparam logic [PROD_W-1:0]  POS_MAX  = PROD_W'(64'h7FFF_FFFF);
  localparam logic [PROD_W-1:0]  NEG_MAX  = PROD_W'(64'h8000_0000);

  // configuration and unwrap state
  logic [RAW_W-1:0]   thresh_q;
  logic [RAW_W-1:0]   last_raw_q;
  logic [TURN_W-1:0]  turn_q, turn_d;
  logic [ANGLE_W-1:0] last_full_q;
  logic [TIMER_W-1:0] last_timer_q;

  // per-beat working registers
  logic [TIMER_W-1:0] dt_q, dt_d;
  logic [ANGLE_W-1:0] full_q;
  logic [DELTA_W-1:0] delta_q;
  logic               neg_q;
  logic [PROD_W-1:0]  quo_q;
  logic [TIMER_W-1:0] rem_q;
  logic [CNT_W-1:0]   cnt_q;
  logic signed [ANGLE_W-1:0] full_angle_q, velocity_q;

  // ---- unwrap and elapsed time, evaluated on the accepted beat ----
  logic [RAW_W:0]     jump;
  logic [RAW_W:0]     jump_mag;
  logic [TIMER_W-1:0] dt_raw;

  always_comb begin
    jump     = {1'b0, raw_angle_i} - {1'b0, last_raw_q};
    jump_mag = jump[RAW_W] ? (~jump + 1'b1) : jump;
    turn_d   = turn_q;
    if (jump_mag[RAW_W-1:0] >= thresh_q) begin
      if (!jump[RAW_W] && (jump != '0)) begin
        turn_d = turn_q - 1'b1;
      end else begin
        turn_d = turn_q + 1'b1;
      end
    end
    // down-counter: difference, or distance through the wrap
    if (timer_count_i < last_timer_q) begin
      dt_raw = last_timer_q - timer_count_i;
    end else begin
      dt_raw = {TIMER_W{1'b1}} - timer_count_i + last_timer_q;
    end
    dt_d = (dt_raw == '0) ? mavu_pkg::DEFAULT_DT : dt_raw;
  end

  // ---- full angle, delta, product ----
  logic [ANGLE_W-1:0] turns_ext;
  logic [ANGLE_W-1:0] full_calc;
  logic [DELTA_W-1:0] delta_calc;
  logic [mavu_pkg::PP_LO_W-1:0] pp_lo;
  logic [mavu_pkg::PP_HI_W-1:0] pp_hi;

  assign turns_ext  = ANGLE_W'($signed(turn_q));
  assign full_calc  = ANGLE_W'(turns_ext * CPR_WORD) + ANGLE_W'(last_raw_q);
  assign delta_calc = {full_q[ANGLE_W-1], full_q} - {last_full_q[ANGLE_W-1], last_full_q};
  assign pp_lo      = delta_q[LO_W-1:0] * mavu_pkg::US_PER_S;
  assign pp_hi      = delta_q[DELTA_W-1:LO_W] * mavu_pkg::US_PER_S;

  // ---- restoring divider, two bits per cycle ----
  logic [TIMER_W:0]   t1, t2;
  logic               ge1, ge2;
  logic [TIMER_W-1:0] r1, r2;

  always_comb begin
    t1  = {rem_q, quo_q[PROD_W-1]};
    ge1 = (t1 >= {1'b0, dt_q});
    r1  = ge1 ? TIMER_W'(t1 - {1'b0, dt_q}) : t1[TIMER_W-1:0];
    t2  = {r1, quo_q[PROD_W-2]};
    ge2 = (t2 >= {1'b0, dt_q});
    r2  = ge2 ? TIMER_W'(t2 - {1'b0, dt_q}) : t2[TIMER_W-1:0];
  end

  assign status_o.div_last = (cnt_q == CNT_LAST);

  // ---- clamp quotient magnitude to signed 32 bits ----
  logic [ANGLE_W-1:0] vel_sat;

  always_comb begin
    if (!neg_q) begin
      vel_sat = (quo_q > POS_MAX) ? POS_MAX[ANGLE_W-1:0] : quo_q[ANGLE_W-1:0];
    end else begin
      vel_sat = (quo_q > NEG_MAX) ? NEG_MAX[ANGLE_W-1:0] : (~quo_q[ANGLE_W-1:0] + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q     <= mavu_pkg::THRESH_RST;
      last_raw_q   <= '0;
      turn_q       <= '0;
      last_full_q  <= '0;
      last_timer_q <= '0;
    end else begin
      if (thresh_we_i) begin
        thresh_q <= thresh_wdata_i;
      end
      if (cmd_i.load) begin
        last_raw_q   <= raw_angle_i;
        turn_q       <= turn_d;
        last_timer_q <= timer_count_i;
      end
      if (cmd_i.calc_delta) begin
        last_full_q <= full_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dt_q <= dt_d;
    end
    if (cmd_i.calc_full) begin
      full_q <= full_calc;
    end
    if (cmd_i.calc_delta) begin
      delta_q <= delta_calc;
      neg_q   <= delta_calc[DELTA_W-1];
    end
    if (cmd_i.calc_abs && neg_q) begin
      delta_q <= ~delta_q + 1'b1;
    end
    if (cmd_i.mul_lo) begin
      quo_q <= PROD_W'(pp_lo);
    end
    if (cmd_i.mul_hi) begin
      quo_q <= quo_q + PROD_W'({pp_hi, {LO_W{1'b0}}});
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      quo_q <= {quo_q[PROD_W-3:0], ge1, ge2};
      rem_q <= r2;
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.out_load) begin
      full_angle_q <= $signed(last_full_q);
      velocity_q   <= $signed(vel_sat);
    end
  end

  assign wrap_threshold_o = thresh_q;
  assign full_angle_o     = full_angle_q;
  assign velocity_o       = velocity_q;

endmodule

`default_nettype wire

FILE: tb/tb_multiturn_angle_and_velocity_unit.sv
// ----------------------------------------------------------------------------
// tb_multiturn_angle_and_velocity_unit
// Self-checking bench for the multi-turn angle and velocity unit. A scoreboard
// class predicts the unwrapped angle and saturated velocity of every accepted
// input beat. Directed corner beats run first, then rotation-like random
// streams under several wrap thresholds and handshake idling mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_multiturn_angle_and_velocity_unit;
  import mavu_pkg::*;

  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 11;
  localparam int IDLE_LIMIT      = 5000;
  localparam int LONG_HOLD       = 300;
  localparam int DRAIN_TAIL      = 40;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 155;
  localparam int N_DIRECTED      = 20;
  localparam longint VEL_MAX     = 2147483647;
  localparam longint VEL_MIN     = -VEL_MAX - 1;
  localparam logic [APB_AW-1:0] THRESH_ADDR = APB_AW'(4 * REG_WRAP_THRESHOLD);

  localparam logic [RAW_W-1:0] PHASE_THRESH [N_PHASES] =
    '{14'd1, 14'd16383, 14'd0, 14'd8192, 14'd4000, 14'd13108, 14'd2, 14'd16382};

  // corner beats, run against the reset threshold
  localparam logic [RAW_W-1:0] DIR_RAW [N_DIRECTED] = '{
    14'd0,     14'd16383, 14'd0,     14'd13108, 14'd0,
    14'd13107, 14'd0,     14'd5,     14'd5,     14'd8000,
    14'd16383, 14'h2AAA,  14'h1555,  14'd16383, 14'd3000,
    14'h3FFF,  14'h3FFF,  14'd0,     14'd16383, 14'd1};
  localparam logic [TIMER_W-1:0] DIR_TIMER [N_DIRECTED] = '{
    16'd65535, 16'd65534, 16'd65534, 16'd65000, 16'd64999,
    16'd64998, 16'd64997, 16'd0,     16'd65535, 16'd1,
    16'd0,     16'hAAAA,  16'h5555,  16'h5554,  16'h5000,
    16'hFFFF,  16'hFFFF,  16'd0,     16'd65535, 16'd65534};

  typedef struct {
    logic signed [ANGLE_W-1:0] full_angle;
    logic signed [ANGLE_W-1:0] velocity;
  } angle_velocity_t;

  class angle_velocity_scoreboard;
    logic [RAW_W-1:0]          wrap_thresh;
    logic [RAW_W-1:0]          prev_raw;
    logic signed [TURN_W-1:0]  turns;
    logic signed [ANGLE_W-1:0] prev_full;
    logic [TIMER_W-1:0]        prev_timer;
    angle_velocity_t           expected_q[$];
    int                        errors;
    int                        checked;

    function new();
      wrap_thresh = THRESH_RST;
      prev_raw    = '0;
      turns       = '0;
      prev_full   = '0;
      prev_timer  = '0;
      errors      = 0;
      checked     = 0;
    endfunction

    function void set_threshold(logic [APB_DW-1:0] wdata);
      wrap_thresh = wdata[RAW_W-1:0];
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [RAW_W-1:0] raw, logic [TIMER_W-1:0] now);
      int              jump;
      int              mag;
      int              dt_us;
      longint          delta;
      longint          vel;
      angle_velocity_t res;
      jump = int'(raw) - int'(prev_raw);
      mag  = (jump < 0) ? -jump : jump;
      // down-counting timer; a non-decreasing sample means it rolled over
      if (now < prev_timer) dt_us = int'(prev_timer) - int'(now);
      else dt_us = 65535 - int'(now) + int'(prev_timer);
      if (dt_us == 0) dt_us = int'(DEFAULT_DT);
      if (mag >= int'(wrap_thresh)) begin
        if (jump > 0) turns = turns - 18'sd1;
        else turns = turns + 18'sd1;
      end
      res.full_angle = ANGLE_W'(longint'(turns) * COUNTS_PER_REV + longint'(raw));
      delta = longint'(res.full_angle) - longint'(prev_full);
      vel   = delta * longint'(US_PER_S) / longint'(dt_us);
      if (vel > VEL_MAX) vel = VEL_MAX;
      if (vel < VEL_MIN) vel = VEL_MIN;
      res.velocity = ANGLE_W'(vel);
      prev_raw   = raw;
      prev_full  = res.full_angle;
      prev_timer = now;
      expected_q.push_back(res);
    endfunction

    function void check_result(logic signed [ANGLE_W-1:0] full_angle,
                               logic signed [ANGLE_W-1:0] velocity);
      angle_velocity_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: full_angle=%0d velocity=%0d",
                 $time, full_angle, velocity);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (full_angle !== want.full_angle) begin
        $display("%0t: full_angle mismatch: expected %0d, actual %0d",
                 $time, want.full_angle, full_angle);
        errors++;
      end
      if (velocity !== want.velocity) begin
        $display("%0t: velocity mismatch: expected %0d, actual %0d",
                 $time, want.velocity, velocity);
        errors++;
      end
    endfunction
  endclass

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       in_valid_i    = 1'b0;
  logic                       in_stall_o;
  logic [RAW_W-1:0]           raw_angle_i   = '0;
  logic [TIMER_W-1:0]         timer_count_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i   = 1'b0;
  logic signed [ANGLE_W-1:0]  full_angle_o;
  logic signed [ANGLE_W-1:0]  velocity_o;
  logic                       psel          = 1'b0;
  logic                       penable       = 1'b0;
  logic                       pwrite        = 1'b0;
  logic [APB_AW-1:0]          paddr         = '0;
  logic [APB_DW-1:0]          pwdata        = '0;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;

  angle_velocity_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req_cnt  = 0;
  int idle_cycles   = 0;
  int read_errors   = 0;
  int rot_speed     = 0;
  logic [RAW_W-1:0]   rot_raw   = '0;
  logic [TIMER_W-1:0] rot_timer = '0;

  multiturn_angle_and_velocity_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .raw_angle_i   (raw_angle_i),
    .timer_count_i (timer_count_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .full_angle_o  (full_angle_o),
    .velocity_o    (velocity_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // receiver: random stall, plus a long hold-off when requested
  int hold_left = 0;
  int hold_seen = 0;
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
        sb.check_result(full_angle_o, velocity_o);
      end
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
    $display("multiturn_angle_and_velocity_unit test failed");
    $finish;
  end

  // all driving tasks start and end at a falling edge
  task automatic apb_write(input logic [APB_DW-1:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= THRESH_ADDR;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    sb.set_threshold(wdata);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_check_threshold();
    logic [APB_DW-1:0] rdata;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= THRESH_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata[RAW_W-1:0] !== sb.wrap_thresh) begin
      $display("%0t: wrap_threshold readback: expected %0d, actual %0d",
               $time, sb.wrap_thresh, rdata[RAW_W-1:0]);
      read_errors++;
    end
  endtask

  task automatic program_threshold(input logic [RAW_W-1:0] thr);
    logic [APB_DW-1:0] wdata;
    // junk in the unused upper bits
    wdata = $urandom();
    wdata[RAW_W-1:0] = thr;
    apb_write(wdata);
    apb_check_threshold();
  endtask

  task automatic send_beat(input logic [RAW_W-1:0] raw, input logic [TIMER_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    raw_angle_i   <= raw;
    timer_count_i <= now;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    sb.note_input(raw, now);
    @(negedge clk_i);
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // mostly a turning shaft with jitter; the rest is jumps and noise
  task automatic next_sample(output logic [RAW_W-1:0] raw, output logic [TIMER_W-1:0] now);
    int pick;
    int step;
    int tdt;
    pick = $urandom_range(99);
    if (pick < 80) begin
      case ($urandom_range(7))
        0: step = 0;
        1: step = int'($urandom_range(32766)) - 16383;
        default: step = rot_speed + int'($urandom_range(200)) - 100;
      endcase
      rot_raw = RAW_W'(int'(rot_raw) + step);
      case ($urandom_range(15))
        0: tdt = 0;
        1: tdt = $urandom_range(65535);
        2: tdt = $urandom_range(3, 1);
        default: tdt = $urandom_range(1500, 1);
      endcase
      rot_timer = rot_timer - TIMER_W'(tdt);
    end else begin
      case ($urandom_range(3))
        0: rot_raw = '0;
        1: rot_raw = '1;
        default: rot_raw = RAW_W'($urandom());
      endcase
      case ($urandom_range(3))
        0: rot_timer = '0;
        1: rot_timer = '1;
        default: rot_timer = TIMER_W'($urandom());
      endcase
    end
    raw = rot_raw;
    now = rot_timer;
  endtask

  initial begin
    logic [RAW_W-1:0]   raw;
    logic [TIMER_W-1:0] now;
    logic [RAW_W-1:0]   thr;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    apb_check_threshold();

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_beat(DIR_RAW[i], DIR_TIMER[i]);
    end
    rot_raw   = DIR_RAW[N_DIRECTED-1];
    rot_timer = DIR_TIMER[N_DIRECTED-1];

    for (int p = 0; p < N_PHASES; p++) begin
      pause_until_drained();
      thr = (p == 4) ? RAW_W'($urandom_range(16383, 1)) : PHASE_THRESH[p];
      program_threshold(thr);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 47; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 47; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      rot_speed = int'($urandom_range(6000)) - 3000;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // long output hold-off while input keeps coming, so the unit backs up
        if (p == 0 && i == 20) hold_req_cnt++;
        if (p == 2 && i == 77) pause_until_drained();
        next_sample(raw, now);
        send_beat(raw, now);
      end
    end

    pause_until_drained();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    $display("Checked %0d result beats across %0d wrap thresholds and four idling mixes,",
             sb.checked, N_PHASES + 1);
    $display("with corner timer intervals, turn wraps, saturation and back-pressure.");
    if (sb.errors == 0 && read_errors == 0 && sb.pending() == 0) begin
      $display("multiturn_angle_and_velocity_unit test passed");
    end else begin
      $display("multiturn_angle_and_velocity_unit test failed");
    end
    $finish;
  end

endmodule
